FILE: hw/rtl/bcbd_pkg.sv
// Shared constants, request codes and status types of the box collision unit.
// Depends on nothing; every other file of the block refers to it.
`default_nettype none

package bcbd_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int IN_COORD_WIDTH  = 32;
	localparam int STEP_WIDTH      = 24;
	localparam logic [STEP_WIDTH-1:0] STEP_RESET = 24'd655360;

	localparam int CORNERS   = 8;
	localparam int BOXES     = 2;
	localparam int DEPTH     = CORNERS * BOXES;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CORNER_W  = $clog2(CORNERS);
	localparam int DIR_COUNT = 4;
	localparam int REQ_W     = 2;

	localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SET_ALL = 2'd1;
	localparam logic [REQ_W-1:0] REQ_EVAL    = 2'd2;

	localparam logic BOX_MOVING = 1'b0;
	localparam logic BOX_TARGET = 1'b1;

	// hits[0] unshifted overlap, hits[1..4] +x, -x, +z, -z probe hits
	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIR_COUNT:0]   hits;
	} eval_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/box_collision_blocked_directions_unit.sv
// Top level of the box collision unit: request decode, step register,
// allowed-direction mask and result register. Uses bcbd_pkg, bcbd_corner_mem, bcbd_eval.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request word: a corner write
//   (box_sel, corner_index, corner_x/y/z), a set-all-allowed, or an evaluate.
//   Corner writes and set-all return nothing. Code 3 is dropped.
//   An evaluate reads the sixteen stored corners twice through the store's single
//   read port, once for box bounds and once for the containment tests, and
//   returns one word (overlap, allowed_dirs) on the output channel; no further
//   request is taken until that word has been placed in the output register.
//   out_valid holds with its word until out_stall is low. While a result waits,
//   writes and set-all requests are still taken; a following evaluate finishes
//   its passes and then holds until the output register is free.
//   cfg_wen writes step_distance from cfg_wdata; write it only while idle.
//   Reset clears the handshake, sets all directions allowed and step_distance
//   to 10.0. Corner contents are undefined until written.
`default_nettype none

module box_collision_blocked_directions_unit #(
	parameter int COORD_WIDTH = bcbd_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_wen,
	input  wire logic [bcbd_pkg::STEP_WIDTH-1:0]         cfg_wdata,
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire logic [bcbd_pkg::REQ_W-1:0]              req_type,
	input  wire logic                                    box_sel,
	input  wire logic [bcbd_pkg::CORNER_W-1:0]           corner_index,
	input  wire logic signed [bcbd_pkg::IN_COORD_WIDTH-1:0] corner_x,
	input  wire logic signed [bcbd_pkg::IN_COORD_WIDTH-1:0] corner_y,
	input  wire logic signed [bcbd_pkg::IN_COORD_WIDTH-1:0] corner_z,
	output logic                                         out_valid,
	input  wire logic                                    out_stall,
	output logic                                         overlap,
	output logic      [bcbd_pkg::DIR_COUNT-1:0]          allowed_dirs
);

	logic [bcbd_pkg::STEP_WIDTH-1:0] step_q;
	logic [bcbd_pkg::DIR_COUNT-1:0]  mask_q;
	logic [bcbd_pkg::DIR_COUNT-1:0]  mask_next;
	logic                            out_valid_q;
	logic                            overlap_q;
	logic [bcbd_pkg::DIR_COUNT-1:0]  dirs_q;

	logic                            in_acc;
	logic                            mem_we;
	logic                            start;
	logic                            out_free;
	logic signed [COORD_WIDTH-1:0]   cx, cy, cz;
	logic                            rd_en;
	logic [bcbd_pkg::ADDR_W-1:0]     rd_addr;
	logic [3*COORD_WIDTH-1:0]        rd_data;
	bcbd_pkg::eval_stat_t            stat;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = stat.busy;
	assign mem_we   = in_acc && (req_type == bcbd_pkg::REQ_WRITE);
	assign start    = in_acc && (req_type == bcbd_pkg::REQ_EVAL);
	assign out_free = !out_valid_q || !out_stall;

	assign cx = COORD_WIDTH'(corner_x);
	assign cy = COORD_WIDTH'(corner_y);
	assign cz = COORD_WIDTH'(corner_z);

	assign mask_next = mask_q & ~stat.hits[bcbd_pkg::DIR_COUNT:1];

	bcbd_corner_mem #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr ({box_sel, corner_index}),
		.wdata ({cz, cy, cx}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	bcbd_eval #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_free (out_free),
		.step     (step_q),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.stat     (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= bcbd_pkg::STEP_RESET;
		end else if (cfg_wen) begin
			step_q <= cfg_wdata;
		end
	end

	// mask: clear on probe hits, refill on set-all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '1;
		end else if (stat.done) begin
			mask_q <= mask_next;
		end else if (in_acc) begin
			case (req_type)
				bcbd_pkg::REQ_SET_ALL: mask_q <= '1;
				default:               mask_q <= mask_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			overlap_q <= stat.hits[0];
			dirs_q    <= mask_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign overlap      = overlap_q;
	assign allowed_dirs = dirs_q;

`ifndef SYNTH
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> in_stall)
		else $error("evaluate accepted without entering busy");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !stat.busy)
		else $error("corner write during evaluation");

	a_mask_refill: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && ((mask_q & ~$past(mask_q)) != '0)) |->
		$past(in_acc && req_type == bcbd_pkg::REQ_SET_ALL))
		else $error("allowed mask gained a bit without set-all");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |=> out_valid)
		else $error("evaluation result lost");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/bcbd_corner_mem.sv
// Corner store: sixteen entries of packed {z, y, x} coordinates.
// One write port, one read port with registered data. Uses bcbd_pkg.
`default_nettype none

module bcbd_corner_mem #(
	parameter int COORD_WIDTH = bcbd_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [bcbd_pkg::ADDR_W-1:0]  waddr,
	input  wire logic [3*COORD_WIDTH-1:0]     wdata,
	input  wire logic                         re,
	input  wire logic [bcbd_pkg::ADDR_W-1:0]  raddr,
	output logic      [3*COORD_WIDTH-1:0]     rdata
);

	logic [3*COORD_WIDTH-1:0] mem_q [0:bcbd_pkg::DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/bcbd_eval.sv
// Evaluate sequencer: a bounds pass and a containment pass over the corner store.
// Drives the store read port and reports probe hits. Uses bcbd_pkg.
`default_nettype none

module bcbd_eval #(
	parameter int COORD_WIDTH = bcbd_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic                               out_free,
	input  wire logic [bcbd_pkg::STEP_WIDTH-1:0]    step,
	output logic                                    rd_en,
	output logic      [bcbd_pkg::ADDR_W-1:0]        rd_addr,
	input  wire logic [3*COORD_WIDTH-1:0]           rd_data,
	output bcbd_pkg::eval_stat_t                    stat
);

	localparam int EXT_W = ((COORD_WIDTH > bcbd_pkg::STEP_WIDTH) ? COORD_WIDTH
		: bcbd_pkg::STEP_WIDTH + 1) + 1;
	localparam logic [bcbd_pkg::ADDR_W-1:0] LAST_ADDR = bcbd_pkg::ADDR_W'(bcbd_pkg::DEPTH - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BND  = 3'd1;
	localparam logic [2:0] ST_TST  = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]                    state_q;
	logic [bcbd_pkg::ADDR_W-1:0]   cnt_q;
	logic                          rv_s1;
	logic                          test_s1;
	logic [bcbd_pkg::ADDR_W-1:0]   ra_s1;
	logic                          v_s2;
	logic                          box_s2;
	logic signed [EXT_W-1:0]       x_s2, y_s2, z_s2, xp_s2, xm_s2, zp_s2, zm_s2;
	logic [bcbd_pkg::DIR_COUNT:0]  hit_q;

	logic signed [COORD_WIDTH-1:0] mlo_q [0:2];
	logic signed [COORD_WIDTH-1:0] mhi_q [0:2];
	logic signed [COORD_WIDTH-1:0] tlo_q [0:2];
	logic signed [COORD_WIDTH-1:0] thi_q [0:2];

	logic signed [COORD_WIDTH-1:0] crd [0:2];
	logic signed [EXT_W-1:0]       s_ext;
	logic                          first;
	logic                          done;

	assign crd[0] = signed'(rd_data[COORD_WIDTH-1:0]);
	assign crd[1] = signed'(rd_data[2*COORD_WIDTH-1:COORD_WIDTH]);
	assign crd[2] = signed'(rd_data[3*COORD_WIDTH-1:2*COORD_WIDTH]);
	assign s_ext  = signed'(EXT_W'(step));
	assign first  = (ra_s1[bcbd_pkg::CORNER_W-1:0] == '0);

	assign rd_en   = (state_q == ST_BND) || (state_q == ST_TST);
	assign rd_addr = cnt_q;
	assign done    = (state_q == ST_DONE) && out_free;

	always_comb begin
		stat.busy = (state_q != ST_IDLE);
		stat.done = done;
		stat.hits = hit_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rv_s1   <= 1'b0;
			test_s1 <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			rv_s1   <= rd_en;
			test_s1 <= (state_q == ST_TST);
			v_s2    <= rv_s1 && test_s1;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						state_q <= ST_BND;
					end
				end
				ST_BND: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_ADDR) begin
						state_q <= ST_TST;
					end
				end
				ST_TST: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_ADDR) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (!rv_s1 && !v_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ra_s1 <= cnt_q;
	end

	// bounds pass: min and max per axis of each box
	always_ff @(posedge clk) begin
		if (rv_s1 && !test_s1) begin
			for (int a = 0; a < 3; a++) begin
				if (ra_s1[bcbd_pkg::ADDR_W-1] == bcbd_pkg::BOX_MOVING) begin
					if (first || crd[a] < mlo_q[a]) mlo_q[a] <= crd[a];
					if (first || crd[a] > mhi_q[a]) mhi_q[a] <= crd[a];
				end else begin
					if (first || crd[a] < tlo_q[a]) tlo_q[a] <= crd[a];
					if (first || crd[a] > thi_q[a]) thi_q[a] <= crd[a];
				end
			end
		end
	end

	// test pass, first stage: form the shifted coordinates
	always_ff @(posedge clk) begin
		if (rv_s1 && test_s1) begin
			box_s2 <= ra_s1[bcbd_pkg::ADDR_W-1];
			x_s2   <= EXT_W'(crd[0]);
			y_s2   <= EXT_W'(crd[1]);
			z_s2   <= EXT_W'(crd[2]);
			xp_s2  <= EXT_W'(crd[0]) + s_ext;
			xm_s2  <= EXT_W'(crd[0]) - s_ext;
			zp_s2  <= EXT_W'(crd[2]) + s_ext;
			zm_s2  <= EXT_W'(crd[2]) - s_ext;
		end
	end

	// test pass, second stage: containment against the other box's bounds
	logic signed [EXT_W-1:0] blo [0:2];
	logic signed [EXT_W-1:0] bhi [0:2];
	logic cx0, cxp, cxm, cy, cz0, czp, czm;
	logic [bcbd_pkg::DIR_COUNT:0] hit_now;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			blo[a] = (box_s2 == bcbd_pkg::BOX_TARGET) ? EXT_W'(mlo_q[a]) : EXT_W'(tlo_q[a]);
			bhi[a] = (box_s2 == bcbd_pkg::BOX_TARGET) ? EXT_W'(mhi_q[a]) : EXT_W'(thi_q[a]);
		end
		cx0 = (blo[0] <= x_s2)  && (x_s2  <= bhi[0]);
		cxp = (blo[0] <= xp_s2) && (xp_s2 <= bhi[0]);
		cxm = (blo[0] <= xm_s2) && (xm_s2 <= bhi[0]);
		cy  = (blo[1] <= y_s2)  && (y_s2  <= bhi[1]);
		cz0 = (blo[2] <= z_s2)  && (z_s2  <= bhi[2]);
		czp = (blo[2] <= zp_s2) && (zp_s2 <= bhi[2]);
		czm = (blo[2] <= zm_s2) && (zm_s2 <= bhi[2]);
		// a target corner sees the moving box shift, so it tests the opposite offset
		hit_now[0] = cx0 && cy && cz0;
		hit_now[1] = (box_s2 ? cxm : cxp) && cy && cz0;
		hit_now[2] = (box_s2 ? cxp : cxm) && cy && cz0;
		hit_now[3] = cx0 && cy && (box_s2 ? czm : czp);
		hit_now[4] = cx0 && cy && (box_s2 ? czp : czm);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
		end else if (start && state_q == ST_IDLE) begin
			hit_q <= '0;
		end else if (v_s2) begin
			hit_q <= hit_q | hit_now;
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for box_collision_blocked_directions_unit: corner loads, set-all and evaluate
// words with random idling on both channels, checked against a built-in box contact predictor.
// Depends on bcbd_pkg and the unit's RTL only.

module tb_top;

	localparam logic [bcbd_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int DIR_POS_X = 0;
	localparam int DIR_NEG_X = 1;
	localparam int DIR_POS_Z = 2;
	localparam int DIR_NEG_Z = 3;
	localparam int RANDOM_WORDS = 1200;
	localparam int STEP_EVERY = 150;
	localparam int HOLD_OFF = 64;
	localparam int DRAIN_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam longint COORD_MAX = 64'sh7FFFFFFF;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	localparam longint ONE = 65536;

	typedef enum logic [1:0] {JOB_WORD, JOB_STEP, JOB_PHASE} job_kind_t;

	typedef struct packed {
		job_kind_t                       kind;
		logic [bcbd_pkg::REQ_W-1:0]      req;
		logic                            box;
		logic [bcbd_pkg::CORNER_W-1:0]   idx;
		logic [31:0]                     x;
		logic [31:0]                     y;
		logic [31:0]                     z;
		logic [bcbd_pkg::STEP_WIDTH-1:0] arg;
	} job_t;

	typedef struct packed {
		logic                           hit;
		logic [bcbd_pkg::DIR_COUNT-1:0] dirs;
	} contact_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [bcbd_pkg::STEP_WIDTH-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [bcbd_pkg::REQ_W-1:0] req_type = '0;
	logic box_sel = 1'b0;
	logic [bcbd_pkg::CORNER_W-1:0] corner_index = '0;
	logic signed [bcbd_pkg::IN_COORD_WIDTH-1:0] corner_x = '0;
	logic signed [bcbd_pkg::IN_COORD_WIDTH-1:0] corner_y = '0;
	logic signed [bcbd_pkg::IN_COORD_WIDTH-1:0] corner_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic overlap;
	logic [bcbd_pkg::DIR_COUNT-1:0] allowed_dirs;

	job_t request_words[$];
	contact_t expected_contacts[$];
	job_t current_word;

	longint pt_x[bcbd_pkg::DEPTH];
	longint pt_y[bcbd_pkg::DEPTH];
	longint pt_z[bcbd_pkg::DEPTH];
	logic [bcbd_pkg::DIR_COUNT-1:0] dir_mask = '1;
	logic [bcbd_pkg::STEP_WIDTH-1:0] step_live = bcbd_pkg::STEP_RESET;
	logic [bcbd_pkg::STEP_WIDTH-1:0] plan_step = bcbd_pkg::STEP_RESET;

	int send_idle_pct = 20;
	int recv_stall_pct = 74;
	int idle_run = 0;
	int word_count = 0;
	int failures = 0;
	int unsigned cycle_count = 0;

	box_collision_blocked_directions_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.box_sel      (box_sel),
		.corner_index (corner_index),
		.corner_x     (corner_x),
		.corner_y     (corner_y),
		.corner_z     (corner_z),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.overlap      (overlap),
		.allowed_dirs (allowed_dirs)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// moving box shifted by (dx, 0, dz) against the target box, corner containment both ways
	function automatic bit shifted_contact(longint dx, longint dz);
		longint lo[2][3];
		longint hi[2][3];
		longint p[3];
		int b;
		bit held;
		bit hit;
		hit = 1'b0;
		for (int i = 0; i < bcbd_pkg::DEPTH; i++) begin
			b = i / bcbd_pkg::CORNERS;
			p[0] = pt_x[i] + ((b == 0) ? dx : 0);
			p[1] = pt_y[i];
			p[2] = pt_z[i] + ((b == 0) ? dz : 0);
			for (int a = 0; a < 3; a++) begin
				if (i % bcbd_pkg::CORNERS == 0 || p[a] < lo[b][a]) lo[b][a] = p[a];
				if (i % bcbd_pkg::CORNERS == 0 || p[a] > hi[b][a]) hi[b][a] = p[a];
			end
		end
		for (int i = 0; i < bcbd_pkg::DEPTH; i++) begin
			b = 1 - i / bcbd_pkg::CORNERS;
			p[0] = pt_x[i] + ((b == 1) ? dx : 0);
			p[1] = pt_y[i];
			p[2] = pt_z[i] + ((b == 1) ? dz : 0);
			held = 1'b1;
			for (int a = 0; a < 3; a++) begin
				if (p[a] < lo[b][a] || p[a] > hi[b][a]) held = 1'b0;
			end
			if (held) hit = 1'b1;
		end
		return hit;
	endfunction

	task automatic track_request(job_t w);
		int slot;
		longint s;
		contact_t c;
		slot = {w.box, w.idx};
		s = longint'(step_live);
		case (w.req)
			bcbd_pkg::REQ_WRITE: begin
				pt_x[slot] = longint'($signed(w.x));
				pt_y[slot] = longint'($signed(w.y));
				pt_z[slot] = longint'($signed(w.z));
			end
			bcbd_pkg::REQ_SET_ALL: dir_mask = '1;
			bcbd_pkg::REQ_EVAL: begin
				c.hit = shifted_contact(0, 0);
				if (shifted_contact(s, 0)) dir_mask[DIR_POS_X] = 1'b0;
				if (shifted_contact(-s, 0)) dir_mask[DIR_NEG_X] = 1'b0;
				if (shifted_contact(0, s)) dir_mask[DIR_POS_Z] = 1'b0;
				if (shifted_contact(0, -s)) dir_mask[DIR_NEG_Z] = 1'b0;
				c.dirs = dir_mask;
				expected_contacts = {expected_contacts, c};
			end
			default: ;
		endcase
	endtask

	// driver: present words, apply step writes once the unit has gone quiet
	always @(posedge clk) begin
		logic nv;
		logic nw;
		job_t head;
		nv = in_valid;
		nw = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				track_request(current_word);
				nv = 1'b0;
			end
			if (in_valid || expected_contacts.size() != 0) idle_run = 0;
			else idle_run = idle_run + 1;
			if (!nv && request_words.size() != 0) begin
				head = request_words[0];
				case (head.kind)
					JOB_PHASE: begin
						void'(request_words.pop_front());
						send_idle_pct = (head.arg == 2) ? 74 : 0;
						recv_stall_pct = (head.arg == 2) ? 20 : 0;
					end
					JOB_STEP: begin
						if (idle_run >= HOLD_OFF) begin
							void'(request_words.pop_front());
							nw = 1'b1;
							cfg_wdata <= head.arg;
							step_live = head.arg;
							idle_run = 0;
						end
					end
					default: begin
						if ($urandom_range(99) >= send_idle_pct) begin
							void'(request_words.pop_front());
							nv = 1'b1;
							current_word = head;
							req_type <= head.req;
							box_sel <= head.box;
							corner_index <= head.idx;
							corner_x <= head.x;
							corner_y <= head.y;
							corner_z <= head.z;
						end
					end
				endcase
			end
		end
		in_valid <= nv;
		cfg_wen <= nw;
	end

	// monitor: compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		contact_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_contacts.size() == 0) begin
					$error("unexpected result word: overlap %0d allowed_dirs %b",
						overlap, allowed_dirs);
					failures = failures + 1;
				end else begin
					want = expected_contacts.pop_front();
					if (overlap !== want.hit) begin
						$error("overlap: expected %0d actual %0d", want.hit, overlap);
						failures = failures + 1;
					end
					if (allowed_dirs !== want.dirs) begin
						$error("allowed_dirs: expected %b actual %b", want.dirs, allowed_dirs);
						failures = failures + 1;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic logic [31:0] clamp32(longint v);
		if (v > COORD_MAX) return COORD_MAX[31:0];
		if (v < COORD_MIN) return COORD_MIN[31:0];
		return v[31:0];
	endfunction

	function automatic longint pick_between(longint lo, longint hi);
		int unsigned r;
		r = $urandom_range(32'(hi - lo), 0);
		return lo + longint'(r);
	endfunction

	function automatic longint rand_coord();
		if ($urandom_range(1)) return longint'($signed($urandom()));
		return pick_between(-(ONE << 8), ONE << 8);
	endfunction

	task automatic put_word(logic [bcbd_pkg::REQ_W-1:0] req, logic box,
			logic [bcbd_pkg::CORNER_W-1:0] idx, logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
		job_t j;
		j.kind = JOB_WORD;
		j.req = req;
		j.box = box;
		j.idx = idx;
		j.x = x;
		j.y = y;
		j.z = z;
		j.arg = '0;
		request_words = {request_words, j};
		if (req != REQ_UNUSED) word_count++;
	endtask

	task automatic put_corner(logic box, logic [bcbd_pkg::CORNER_W-1:0] idx, longint x,
			longint y, longint z);
		put_word(bcbd_pkg::REQ_WRITE, box, idx, clamp32(x), clamp32(y), clamp32(z));
	endtask

	// fields other than the request code are don't-care here: fill with noise
	task automatic put_req(logic [bcbd_pkg::REQ_W-1:0] req);
		put_word(req, 1'($urandom()), 3'($urandom()), $urandom(), $urandom(), $urandom());
	endtask

	task automatic put_control(job_kind_t kind, logic [bcbd_pkg::STEP_WIDTH-1:0] arg);
		job_t j;
		j = '0;
		j.kind = kind;
		j.arg = arg;
		request_words = {request_words, j};
		if (kind == JOB_STEP) plan_step = arg;
	endtask

	// two boxes placed near each other, sized against the step so probes hit sometimes
	task automatic put_scene();
		longint span;
		longint reach;
		longint half[2][3];
		longint base[2][3];
		longint p[3];
		bit far_out;
		span = longint'(plan_step) + ONE;
		far_out = ($urandom_range(9) == 0);
		for (int a = 0; a < 3; a++) begin
			base[0][a] = far_out ? longint'($signed($urandom()))
				: pick_between(-(ONE << 8), ONE << 8);
			half[0][a] = pick_between(0, span);
			half[1][a] = pick_between(0, span);
			reach = half[0][a] + half[1][a] + ((a == 1) ? span / 4 : 2 * span);
			base[1][a] = base[0][a] + pick_between(-reach, reach);
		end
		for (int b = 0; b < bcbd_pkg::BOXES; b++) begin
			for (int i = 0; i < bcbd_pkg::CORNERS; i++) begin
				for (int a = 0; a < 3; a++) begin
					p[a] = base[b][a] + (((i >> a) & 1) ? half[b][a] : -half[b][a]);
				end
				if ($urandom_range(19) == 0) p[$urandom_range(2)] = longint'($signed($urandom()));
				put_corner(b[0], i[bcbd_pkg::CORNER_W-1:0], p[0], p[1], p[2]);
			end
		end
	endtask

	initial begin
		int stop_at;
		int next_step_at;
		int step_pick;
		int phase;
		int pick;
		logic [bcbd_pkg::STEP_WIDTH-1:0] step_val;

		// unit cube at the origin inside a target spanning the whole coordinate range
		for (int i = 0; i < bcbd_pkg::CORNERS; i++) begin
			put_corner(bcbd_pkg::BOX_MOVING, i[bcbd_pkg::CORNER_W-1:0], (i & 1) ? ONE : 0,
				(i & 2) ? ONE : 0, (i & 4) ? ONE : 0);
			put_corner(bcbd_pkg::BOX_TARGET, i[bcbd_pkg::CORNER_W-1:0],
				(i & 1) ? COORD_MAX : COORD_MIN, (i & 2) ? COORD_MAX : COORD_MIN,
				(i & 4) ? COORD_MAX : COORD_MIN);
		end
		put_req(bcbd_pkg::REQ_EVAL);
		put_req(REQ_UNUSED);
		put_req(bcbd_pkg::REQ_SET_ALL);
		// target touching the +x probe exactly one step away
		for (int i = 0; i < bcbd_pkg::CORNERS; i++) begin
			put_corner(bcbd_pkg::BOX_TARGET, i[bcbd_pkg::CORNER_W-1:0],
				longint'(bcbd_pkg::STEP_RESET) + ((i & 1) ? 2 * ONE : ONE),
				(i & 2) ? ONE : 0, (i & 4) ? ONE : 0);
		end
		put_req(bcbd_pkg::REQ_EVAL);

		stop_at = word_count + RANDOM_WORDS;
		next_step_at = word_count;
		step_pick = 0;
		phase = 1;
		while (word_count < stop_at) begin
			if (word_count >= next_step_at) begin
				case (step_pick % 8)
					0: step_val = '0;
					1: step_val = 24'd8388608;
					2: step_val = 24'd1;
					3: step_val = 24'(ONE);
					4: step_val = 24'd8388607;
					5: step_val = bcbd_pkg::STEP_RESET;
					default: step_val = 24'($urandom_range(8388608));
				endcase
				put_control(JOB_STEP, step_val);
				step_pick++;
				next_step_at += STEP_EVERY;
			end
			if (phase < 3 && word_count >= stop_at - RANDOM_WORDS + phase * RANDOM_WORDS / 3) begin
				phase++;
				put_control(JOB_PHASE, bcbd_pkg::STEP_WIDTH'(phase));
			end
			pick = $urandom_range(19);
			if (pick < 11) begin
				put_scene();
				repeat ($urandom_range(3, 1)) begin
					if ($urandom_range(3) == 0) put_req(bcbd_pkg::REQ_SET_ALL);
					put_req(bcbd_pkg::REQ_EVAL);
				end
			end else if (pick < 15) begin
				repeat ($urandom_range(3, 1)) begin
					put_corner(1'($urandom()), 3'($urandom()), rand_coord(), rand_coord(),
						rand_coord());
				end
				put_req(bcbd_pkg::REQ_EVAL);
			end else if (pick < 17) begin
				put_req(bcbd_pkg::REQ_SET_ALL);
				put_req(bcbd_pkg::REQ_EVAL);
			end else if (pick < 19) begin
				put_req(REQ_UNUSED);
			end else begin
				put_req(bcbd_pkg::REQ_EVAL);
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (request_words.size() != 0 || in_valid || expected_contacts.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("PASS box_collision_blocked_directions_unit");
		end else begin
			$display("FAIL box_collision_blocked_directions_unit");
		end
		$finish;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL box_collision_blocked_directions_unit");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/bcbd_pkg.sv
hw/rtl/bcbd_corner_mem.sv
hw/rtl/bcbd_eval.sv
hw/rtl/box_collision_blocked_directions_unit.sv
tb/sv/tb_top.sv
